>>> hw/rtl/ppgbd_pkg.sv
// Shared constants, types and the filter weight table for the PPG beat detector.
// Used by every module of the block but ppgbd_ram; depends on nothing else.
`timescale 1ns / 1ps

package ppgbd_pkg;

  localparam int DATA_W         = 16;
  localparam int RING_DEPTH_DEF = 32;
  localparam int DC_SHIFT_DEF   = 4;

  // Filter shape: twelve weights, the centre tap stands alone.
  localparam int TAP_COUNT    = 12;
  localparam int TAP_CENTRE   = 11;
  localparam int TAP_SPAN     = 22;
  localparam int CNT_W        = 4;
  localparam int COEF_W       = 13;
  localparam int DRAIN_CYCLES = 3;

  // Configuration register map.
  localparam int  PADDR_W         = 3;
  localparam logic REG_MIN_SWING  = 1'b0;
  localparam logic REG_MAX_SWING  = 1'b1;
  localparam logic [DATA_W-1:0] MIN_SWING_RST = 16'd20;
  localparam logic [DATA_W-1:0] MAX_SWING_RST = 16'd1000;

  typedef struct packed {
    logic             load_sample;
    logic             dc_update;
    logic             ring_write;
    logic             clear_sum;
    logic             tap_issue;
    logic [CNT_W-1:0] tap_idx;
    logic             finish;
  } ppgbd_cmd_t;

  typedef struct packed {
    logic out_free;
  } ppgbd_status_t;

  function automatic logic [COEF_W-1:0] tap_weight(input logic [CNT_W-1:0] idx);
    logic [COEF_W-1:0] w;
    case (idx)
      4'd0:    w = 13'd172;
      4'd1:    w = 13'd321;
      4'd2:    w = 13'd579;
      4'd3:    w = 13'd927;
      4'd4:    w = 13'd1360;
      4'd5:    w = 13'd1858;
      4'd6:    w = 13'd2390;
      4'd7:    w = 13'd2916;
      4'd8:    w = 13'd3391;
      4'd9:    w = 13'd3768;
      4'd10:   w = 13'd4012;
      4'd11:   w = 13'd4096;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/ppgbd_if.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on ppgbd_pkg for the data width.
`timescale 1ns / 1ps

interface ppgbd_sample_if import ppgbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] ir_sample;

  modport source (output valid, output ir_sample, input ready);
  modport sink   (input valid, input ir_sample, output ready);
endinterface

interface ppgbd_result_if import ppgbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     beat_detected;
  logic signed [DATA_W-1:0] ac_value;
  logic        [DATA_W-1:0] dc_estimate;

  modport source (output valid, output beat_detected, output ac_value,
                  output dc_estimate, input ready);
  modport sink   (input valid, input beat_detected, input ac_value,
                  input dc_estimate, output ready);
endinterface

>>> hw/rtl/ppgbd_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppgbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hw/rtl/ppgbd_ctrl.sv
// Sequencing state machine for the PPG beat detector.
// Depends on ppgbd_pkg for the command and status types.
`timescale 1ns / 1ps

module ppgbd_ctrl import ppgbd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ppgbd_status_t status,
  output ppgbd_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DC    = 6'b000010,
    S_WR    = 6'b000100,
    S_MAC   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DET   = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.tap_idx = cnt;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = S_DC;
        end
      end
      S_DC: begin
        cmd.dc_update = 1'b1;
        state_next    = S_WR;
      end
      S_WR: begin
        cmd.ring_write = 1'b1;
        cmd.clear_sum  = 1'b1;
        cnt_next       = '0;
        state_next     = S_MAC;
      end
      S_MAC: begin
        cmd.tap_issue = 1'b1;
        if (cnt == CNT_W'(TAP_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        // Wait for the last pair to pass the add, multiply and accumulate stages.
        if (cnt == CNT_W'(DRAIN_CYCLES - 1)) begin
          cnt_next   = '0;
          state_next = S_DET;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DET: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/ppgbd_datapath.sv
// Datapath: DC tracker, delay line, shared multiply-accumulate, crossing
// detector and output register. Depends on ppgbd_pkg, ppgbd_if and ppgbd_ram.
`timescale 1ns / 1ps

module ppgbd_datapath import ppgbd_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int DC_SHIFT   = DC_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ppgbd_cmd_t           cmd,
  output ppgbd_status_t        status,
  input  logic [DATA_W-1:0]    ir_sample,
  input  logic [DATA_W-1:0]    min_swing,
  input  logic [DATA_W-1:0]    max_swing,
  ppgbd_result_if.source       results
);

  localparam int AW = $clog2(RING_DEPTH);

  // Sample and DC level.
  logic        [DATA_W-1:0] x;
  logic signed [31:0]       acc;
  logic signed [31:0]       acc_next;
  logic signed [33:0]       diff;
  logic signed [33:0]       step;
  logic        [DATA_W-1:0] dc;

  always_comb begin
    diff     = $signed({3'b000, x, 15'd0}) - 34'(acc);
    step     = diff >>> DC_SHIFT;
    acc_next = acc + step[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      x <= ir_sample;
    end
    if (cmd.dc_update) begin
      dc <= acc_next[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.dc_update) begin
      acc <= acc_next;
    end
  end

  // Delay line: a RAM plus one valid bit per entry, so unwritten entries read as zero.
  logic [AW-1:0]         wp;
  logic [RING_DEPTH-1:0] ring_valid;
  logic [AW:0]           back_a, back_b, wp_ext;
  logic [AW-1:0]         addr_a, addr_b;
  logic [DATA_W-1:0]     ram_a, ram_b;
  logic                  va, vb;

  always_comb begin
    wp_ext = {1'b0, wp};
    back_a = (AW+1)'(cmd.tap_idx);
    back_b = (AW+1)'(TAP_SPAN) - back_a;
    if (wp_ext >= back_a) begin
      addr_a = AW'(wp_ext - back_a);
    end else begin
      addr_a = AW'(wp_ext + (AW+1)'(RING_DEPTH) - back_a);
    end
    if (wp_ext >= back_b) begin
      addr_b = AW'(wp_ext - back_b);
    end else begin
      addr_b = AW'(wp_ext + (AW+1)'(RING_DEPTH) - back_b);
    end
  end

  ppgbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (cmd.ring_write),
    .waddr   (wp),
    .wdata   (x - dc),
    .raddr_a (addr_a),
    .rdata_a (ram_a),
    .raddr_b (addr_b),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      ring_valid <= '0;
    end else begin
      if (cmd.ring_write) begin
        ring_valid[wp] <= 1'b1;
      end
      if (cmd.finish) begin
        wp <= (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  // Multiply-accumulate pipeline: read, pair add, multiply, accumulate.
  logic                     rd_vld, pair_vld, prod_vld;
  logic [CNT_W-1:0]         rd_tag, pair_tag;
  logic        [DATA_W-1:0] tap_a, tap_b;
  logic signed [DATA_W-1:0] pair;
  logic signed [29:0]       prod;
  logic signed [31:0]       sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      pair_vld <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.tap_issue;
      pair_vld <= rd_vld;
      prod_vld <= pair_vld;
    end
  end

  always_comb begin
    tap_a = va ? ram_a : '0;
    tap_b = vb ? ram_b : '0;
  end

  always_ff @(posedge clk) begin
    va       <= ring_valid[addr_a];
    vb       <= ring_valid[addr_b];
    rd_tag   <= cmd.tap_idx;
    pair_tag <= rd_tag;
    if (rd_tag == CNT_W'(TAP_CENTRE)) begin
      pair <= $signed(tap_a);
    end else begin
      pair <= $signed(tap_a + tap_b);
    end
    prod <= pair * $signed({1'b0, tap_weight(pair_tag)});
    if (cmd.clear_sum) begin
      sum <= '0;
    end else if (prod_vld) begin
      sum <= sum + 32'(prod);
    end
  end

  // Crossing detector and excursion tracking.
  logic signed [DATA_W-1:0] cur, last_ac, pos_ext, neg_ext;
  logic signed [DATA_W-1:0] pos_next, neg_next;
  logic                     rising, falling, rising_next, falling_next;
  logic                     rise, fall, beat;
  logic signed [17:0]       swing;

  always_comb begin
    cur   = sum[30:15];
    rise  = (last_ac < 0) && (cur >= 0);
    fall  = (last_ac > 0) && (cur <= 0);
    swing = 18'(pos_ext) - 18'(neg_ext);
    beat  = rise && (swing > $signed({2'b00, min_swing}))
                 && (swing < $signed({2'b00, max_swing}));

    rising_next  = rising;
    falling_next = falling;
    pos_next     = pos_ext;
    neg_next     = neg_ext;
    if (rise) begin
      rising_next  = 1'b1;
      falling_next = 1'b0;
      pos_next     = '0;
    end
    if (fall) begin
      rising_next  = 1'b0;
      falling_next = 1'b1;
      neg_next     = '0;
    end
    if (rising_next && (cur > last_ac)) begin
      pos_next = cur;
    end
    if (falling_next && (cur < last_ac)) begin
      neg_next = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ac <= '0;
      pos_ext <= '0;
      neg_ext <= '0;
      rising  <= 1'b0;
      falling <= 1'b0;
    end else if (cmd.finish) begin
      last_ac <= cur;
      pos_ext <= pos_next;
      neg_ext <= neg_next;
      rising  <= rising_next;
      falling <= falling_next;
    end
  end

  // Output register.
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      results.beat_detected <= beat;
      results.ac_value      <= cur;
      results.dc_estimate   <= dc;
    end
  end

  assign results.valid   = out_valid;
  assign status.out_free = !out_valid || results.ready;

endmodule

>>> hw/rtl/ppg_beat_detector.sv
// Top level of the PPG beat detector: configuration registers and the
// controller/datapath pair. Depends on ppgbd_pkg, ppgbd_if, ppgbd_ctrl, ppgbd_datapath.
//
// Usage: one 16-bit infrared sample word enters on the samples channel and
// exactly one result word leaves on the results channel for it, carrying the
// beat flag, the filtered AC value and the integer DC estimate.
// A word is taken when valid and ready are both high at a rising edge of clk.
// A new word is taken only once the result of the last one is in the output
// register. Each word passes through DC update, delay-line write, twelve steps
// through the single shared multiply-accumulate unit, a pipeline drain, and
// then detection and hand-over, in that order.
// The result waits in an output register, so a stalled receiver holds it
// there; the next word is still taken and worked on, and only its own hand-over
// waits until the output register is free. Nothing is dropped.
// Reset (rst, synchronous, active high) clears the DC accumulator, the delay
// line (through per-entry valid bits), the crossing tracker and both
// channels, and sets the swing limits to 20 and 1000.
// The swing limits are written over the APB port at byte addresses 0 and 4.
`timescale 1ns / 1ps

module ppg_beat_detector import ppgbd_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int DC_SHIFT   = DC_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  ppgbd_sample_if.sink       samples,
  ppgbd_result_if.source     results
);

  // Swing limits. Bit 2 of the address picks the register; the low bits
  // are ignored, so every write lands on one of the two.
  logic [DATA_W-1:0] min_swing;
  logic [DATA_W-1:0] max_swing;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_swing <= MIN_SWING_RST;
      max_swing <= MAX_SWING_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MAX_SWING) begin
        max_swing <= pwdata[DATA_W-1:0];
      end else begin
        min_swing <= pwdata[DATA_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MIN_SWING) begin
      prdata = {16'd0, min_swing};
    end else begin
      prdata = {16'd0, max_swing};
    end
  end

  // The controller sequences each word; the datapath does the arithmetic.
  ppgbd_cmd_t    cmd;
  ppgbd_status_t status;
  logic          in_ready;

  assign samples.ready = in_ready;

  ppgbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ppgbd_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .DC_SHIFT   (DC_SHIFT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .ir_sample (samples.ir_sample),
    .min_swing (min_swing),
    .max_swing (max_swing),
    .results   (results)
  );

endmodule
